// ===== design/pcc_pkg.sv =====
// Shared types, widths and defaults for the per-feature Pearson correlation block.
package pcc_pkg;

    localparam int DEF_FEATURES    = 14;
    localparam int DEF_MAX_SAMPLES = 4096;

    localparam int X_W      = 16;
    localparam int Y_W      = 16;
    localparam int IDX_O_W  = 6;
    localparam int CORR_W   = 16;

    // Sum widths cover the largest sample count the block supports.
    localparam int N_W      = 17;
    localparam int SX_W     = 33;
    localparam int SXX_W    = 49;
    localparam int SXY_W    = 49;
    localparam int SY_W     = 33;
    localparam int SYY_W    = 47;

    // Back-end arithmetic widths.
    localparam int D_W      = 66;
    localparam int MC_W     = 17;
    localparam int MSTEPS   = 4;
    localparam int MA_W     = MC_W * MSTEPS;
    localparam int P_W      = 2 * MA_W;
    localparam int NSQ_W    = 2 * D_W;
    localparam int FRAC_SH  = 32;
    localparam int Q_W      = 35;
    localparam int U_W      = 18;

    localparam int Q_DEPTH  = 2;

    typedef struct packed {
        logic [IDX_O_W-1:0]      idx;
        logic                    last;
        logic [N_W-1:0]          n;
        logic [SX_W-1:0]         sx;
        logic [SXX_W-1:0]        sxx;
        logic signed [SXY_W-1:0] sxy;
        logic signed [SY_W-1:0]  sy;
        logic [SYY_W-1:0]        syy;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== design/per_feature_pearson_correlation_top.sv =====
// Top level of the per-feature Pearson correlation block.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_valid/s_ready    feature_value, target_value,
//                                           end_of_sample, end_of_dataset
//   m_*       out        m_valid/m_ready    feature_index, correlation,
//                                           undefined, last_result
//
// Elements are accumulated at one per cycle. The request that ends a dataset
// starts a drain of one job per feature, which stalls while the job queue is full,
// and s_ready is low during the drain.
// Each feature result in the back end takes eight products on the shared
// 68x17 multiplier, a 35-step restoring divider, an 18-step square root,
// and one step each to pop, prepare, set up the divider, finish and load
// the result register. A zero variance goes from prepare straight to the
// result register; a saturated coefficient skips the divider and square root.
// aresetn is synchronous and active low; it clears all sums.
// m_valid holds until m_ready; the front keeps taking elements meanwhile.
module per_feature_pearson_correlation_top import pcc_pkg::*; #(
    parameter int FEATURES    = DEF_FEATURES,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [X_W-1:0]           s_feature_value,
    input  logic signed [Y_W-1:0]    s_target_value,
    input  logic                     s_end_of_sample,
    input  logic                     s_end_of_dataset,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_O_W-1:0]       m_feature_index,
    output logic signed [CORR_W-1:0] m_correlation,
    output logic                     m_undefined,
    output logic                     m_last_result
);

    // front -> queue
    logic    q_push;
    job_t    q_job_in;
    // queue -> back
    logic    q_pop;
    job_t    q_job_out;
    q_stat_t q_stat;
    // back <-> multiplier
    logic            mul_start;
    logic [MA_W-1:0] mul_a;
    logic [MA_W-1:0] mul_b;
    logic            mul_done;
    logic [P_W-1:0]  mul_p;

    // accumulate sums and hand over one job per feature at dataset end
    pcc_front #(
        .FEATURES    (FEATURES),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_feature_value  (s_feature_value),
        .s_target_value   (s_target_value),
        .s_end_of_sample  (s_end_of_sample),
        .s_end_of_dataset (s_end_of_dataset),
        .q_push           (q_push),
        .q_job            (q_job_in),
        .q_stat           (q_stat)
    );

    // decouple the two sides
    pcc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .job_in  (q_job_in),
        .pop     (q_pop),
        .job_out (q_job_out),
        .stat    (q_stat)
    );

    // shared multiplier for the back end
    pcc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    // compute each coefficient and drive the result register
    pcc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_stat          (q_stat),
        .job_in          (q_job_out),
        .pop             (q_pop),
        .mul_start       (mul_start),
        .mul_a           (mul_a),
        .mul_b           (mul_b),
        .mul_done        (mul_done),
        .mul_p           (mul_p),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_feature_index (m_feature_index),
        .m_correlation   (m_correlation),
        .m_undefined     (m_undefined),
        .m_last_result   (m_last_result)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_stat.empty))
        else $error("job popped from an empty queue");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_undefined) |-> (m_correlation == '0))
        else $error("undefined result carries a nonzero coefficient");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_result) |-> (m_feature_index == IDX_O_W'(FEATURES - 1)))
        else $error("last result flag on the wrong feature");
`endif

endmodule

// ===== design/pcc_front.sv =====
// Front end: accepts elements, accumulates the sums, and drains one job per feature.
module pcc_front import pcc_pkg::*; #(
    parameter int FEATURES    = DEF_FEATURES,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [X_W-1:0]        s_feature_value,
    input  logic signed [Y_W-1:0] s_target_value,
    input  logic                  s_end_of_sample,
    input  logic                  s_end_of_dataset,
    output logic                  q_push,
    output job_t                  q_job,
    input  q_stat_t               q_stat
);

    localparam int IDX_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FEATURES - 1);

    logic [SX_W-1:0]         sx_reg  [FEATURES];
    logic [SXX_W-1:0]        sxx_reg [FEATURES];
    logic signed [SXY_W-1:0] sxy_reg [FEATURES];
    logic signed [SY_W-1:0]  sy_reg;
    logic [SYY_W-1:0]        syy_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        pos_reg;
    logic [IDX_W-1:0]        didx_reg;
    logic                    drain_reg;

    logic                      accept;
    logic                      live;
    logic                      end_s;
    logic [IDX_W-1:0]          ridx;
    logic [2*X_W-1:0]          xsq;
    logic signed [X_W:0]       xs;
    logic signed [X_W+Y_W:0]   xy;
    logic signed [2*Y_W-1:0]   ysq;

    assign s_ready = !drain_reg;
    assign accept  = s_valid && s_ready;
    assign live    = cnt_reg < CNT_W'(MAX_SAMPLES);
    assign end_s   = s_end_of_sample || s_end_of_dataset || (pos_reg == LAST_POS);
    assign ridx    = drain_reg ? didx_reg : pos_reg;
    assign xsq     = s_feature_value * s_feature_value;
    assign xs      = $signed({1'b0, s_feature_value});
    assign xy      = xs * s_target_value;
    assign ysq     = s_target_value * s_target_value;
    assign q_push  = drain_reg && !q_stat.full;

    always_comb begin
        q_job.idx  = IDX_O_W'(didx_reg);
        q_job.last = (didx_reg == LAST_POS);
        q_job.n    = N_W'(cnt_reg);
        q_job.sx   = sx_reg[ridx];
        q_job.sxx  = sxx_reg[ridx];
        q_job.sxy  = sxy_reg[ridx];
        q_job.sy   = sy_reg;
        q_job.syy  = syy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FEATURES; i++) begin
                sx_reg[i]  <= '0;
                sxx_reg[i] <= '0;
                sxy_reg[i] <= '0;
            end
            sy_reg    <= '0;
            syy_reg   <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            didx_reg  <= '0;
            drain_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (live) begin
                    sx_reg[ridx]  <= sx_reg[ridx] + SX_W'(s_feature_value);
                    sxx_reg[ridx] <= sxx_reg[ridx] + SXX_W'(xsq);
                    sxy_reg[ridx] <= sxy_reg[ridx] + SXY_W'(xy);
                end
                if (end_s) begin
                    pos_reg <= '0;
                    if (live) begin
                        sy_reg  <= sy_reg + SY_W'(s_target_value);
                        syy_reg <= syy_reg + SYY_W'($unsigned(ysq));
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (s_end_of_dataset) begin
                    drain_reg <= 1'b1;
                    didx_reg  <= '0;
                end
            end
            if (q_push) begin
                // hand the entry over and clear it for the next dataset
                sx_reg[ridx]  <= '0;
                sxx_reg[ridx] <= '0;
                sxy_reg[ridx] <= '0;
                didx_reg      <= didx_reg + 1'b1;
                if (didx_reg == LAST_POS) begin
                    drain_reg <= 1'b0;
                    sy_reg    <= '0;
                    syy_reg   <= '0;
                    cnt_reg   <= '0;
                end
            end
        end
    end

endmodule

// ===== design/pcc_queue.sv =====
// Two-entry job queue between the front and back ends.
module pcc_queue import pcc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  job_t    job_in,
    input  logic    pop,
    output job_t    job_out,
    output q_stat_t stat
);

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    job_t             mem_reg [Q_DEPTH];
    logic             wp_reg;
    logic             rp_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign job_out    = mem_reg[rp_reg];
    assign stat.full  = (cnt_reg == CNT_W'(Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/pcc_mul.sv =====
// Sequential multiplier: one 68x17 partial product per cycle.
module pcc_mul import pcc_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [MA_W-1:0] a,
    input  logic [MA_W-1:0] b,
    output logic            done,
    output logic [P_W-1:0]  p
);

    localparam int SC_W = (MSTEPS > 1) ? $clog2(MSTEPS) : 1;

    logic [MA_W-1:0]      a_reg;
    logic [MA_W-1:0]      b_reg;
    logic [P_W-1:0]       acc_reg;
    logic [SC_W-1:0]      cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MA_W+MC_W-1:0] partial;

    assign partial = a_reg * b_reg[MA_W-1 -: MC_W];
    assign done    = done_reg;
    assign p       = acc_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= (acc_reg << MC_W) + P_W'(partial);
            b_reg   <= b_reg << MC_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SC_W'(MSTEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/pcc_back.sv =====
// Back end: per-feature products, division, square root and result register.
module pcc_back import pcc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  q_stat_t                  q_stat,
    input  job_t                     job_in,
    output logic                     pop,
    output logic                     mul_start,
    output logic [MA_W-1:0]          mul_a,
    output logic [MA_W-1:0]          mul_b,
    input  logic                     mul_done,
    input  logic [P_W-1:0]           mul_p,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [IDX_O_W-1:0]       m_feature_index,
    output logic signed [CORR_W-1:0] m_correlation,
    output logic                     m_undefined,
    output logic                     m_last_result
);

    typedef enum logic [8:0] {
        B_IDLE    = 9'b000000001,
        B_MSTART  = 9'b000000010,
        B_MWAIT   = 9'b000000100,
        B_PREP    = 9'b000001000,
        B_DIVINIT = 9'b000010000,
        B_DIV     = 9'b000100000,
        B_SQRT    = 9'b001000000,
        B_FIN     = 9'b010000000,
        B_OUT     = 9'b100000000
    } bstate_t;

    localparam logic [2:0] ST_NSYY = 3'd0;
    localparam logic [2:0] ST_SYSQ = 3'd1;
    localparam logic [2:0] ST_NSXX = 3'd2;
    localparam logic [2:0] ST_SXSQ = 3'd3;
    localparam logic [2:0] ST_NSXY = 3'd4;
    localparam logic [2:0] ST_SXSY = 3'd5;
    localparam logic [2:0] ST_DEN  = 3'd6;
    localparam logic [2:0] ST_NSQ  = 3'd7;

    localparam int IT_W = 6;
    localparam int M_W  = CORR_W + 1;
    localparam logic [M_W-1:0] M_FULL = M_W'(1) << (CORR_W - 1);
    localparam logic [M_W-1:0] M_POS  = M_FULL - 1'b1;

    bstate_t             state_reg;
    logic [2:0]          step_reg;
    job_t                job_reg;
    logic [D_W-1:0]      t0_reg;
    logic [D_W-1:0]      dx_reg;
    logic [D_W-1:0]      dy_reg;
    logic [D_W-1:0]      a_reg;
    logic [D_W-1:0]      b_reg;
    logic [D_W-1:0]      num_reg;
    logic                neg_reg;
    logic                undef_reg;
    logic                sat_reg;
    logic [NSQ_W-1:0]    den_reg;
    logic [NSQ_W-1:0]    nsq_reg;
    logic [NSQ_W-1:0]    rem_reg;
    logic [Q_W-1:0]      rlow_reg;
    logic [Q_W-1:0]      q_reg;
    logic [U_W-1:0]      u_reg;
    logic [IT_W-1:0]     it_reg;
    logic signed [CORR_W-1:0] corr_reg;

    logic                      m_valid_reg;
    logic [IDX_O_W-1:0]        m_idx_reg;
    logic signed [CORR_W-1:0]  m_corr_reg;
    logic                      m_undef_reg;
    logic                      m_last_reg;

    logic [SXY_W-1:0]    sxy_mag;
    logic [SY_W-1:0]     sy_mag;
    logic [D_W-1:0]      prod_d;
    logic [D_W-1:0]      diff_d;
    logic [NSQ_W:0]      rem2;
    logic                ge;
    logic [U_W-1:0]      trial;
    logic [2*U_W-1:0]    trial_sq;
    logic [U_W:0]        u_inc;
    logic [M_W-1:0]      m_val;

    assign sxy_mag  = job_reg.sxy[SXY_W-1] ? SXY_W'(-job_reg.sxy) : SXY_W'(job_reg.sxy);
    assign sy_mag   = job_reg.sy[SY_W-1] ? SY_W'(-job_reg.sy) : SY_W'(job_reg.sy);
    assign prod_d   = mul_p[D_W-1:0];
    assign diff_d   = (t0_reg > prod_d) ? (t0_reg - prod_d) : '0;
    assign rem2     = {rem_reg, rlow_reg[Q_W-1]};
    assign ge       = rem2 >= {1'b0, den_reg};
    assign trial    = u_reg | ({1'b1, {(U_W-1){1'b0}}} >> it_reg);
    assign trial_sq = trial * trial;
    assign u_inc    = {1'b0, u_reg} + 1'b1;

    always_comb begin
        if (sat_reg) begin
            m_val = M_FULL;
        end else if (M_W'(u_inc >> 1) > M_FULL) begin
            m_val = M_FULL;
        end else begin
            m_val = M_W'(u_inc >> 1);
        end
    end

    always_comb begin
        case (step_reg)
            ST_NSYY: begin
                mul_a = MA_W'(job_reg.n);
                mul_b = MA_W'(job_reg.syy);
            end
            ST_SYSQ: begin
                mul_a = MA_W'(sy_mag);
                mul_b = MA_W'(sy_mag);
            end
            ST_NSXX: begin
                mul_a = MA_W'(job_reg.n);
                mul_b = MA_W'(job_reg.sxx);
            end
            ST_SXSQ: begin
                mul_a = MA_W'(job_reg.sx);
                mul_b = MA_W'(job_reg.sx);
            end
            ST_NSXY: begin
                mul_a = MA_W'(job_reg.n);
                mul_b = MA_W'(sxy_mag);
            end
            ST_SXSY: begin
                mul_a = MA_W'(job_reg.sx);
                mul_b = MA_W'(sy_mag);
            end
            ST_DEN: begin
                mul_a = MA_W'(dx_reg);
                mul_b = MA_W'(dy_reg);
            end
            ST_NSQ: begin
                mul_a = MA_W'(num_reg);
                mul_b = MA_W'(num_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pop       = (state_reg == B_IDLE) && !q_stat.empty;
    assign mul_start = (state_reg == B_MSTART);

    assign m_valid         = m_valid_reg;
    assign m_feature_index = m_idx_reg;
    assign m_correlation   = m_corr_reg;
    assign m_undefined     = m_undef_reg;
    assign m_last_result   = m_last_reg;

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            B_IDLE: begin
                job_reg <= job_in;
            end
            B_MWAIT: begin
                if (mul_done) begin
                    case (step_reg)
                        ST_NSYY: t0_reg  <= prod_d;
                        ST_SYSQ: dy_reg  <= diff_d;
                        ST_NSXX: t0_reg  <= prod_d;
                        ST_SXSQ: dx_reg  <= diff_d;
                        ST_NSXY: a_reg   <= prod_d;
                        ST_SXSY: b_reg   <= prod_d;
                        ST_DEN:  den_reg <= mul_p[NSQ_W-1:0];
                        ST_NSQ:  nsq_reg <= mul_p[NSQ_W-1:0];
                        default: t0_reg  <= t0_reg;
                    endcase
                end
            end
            B_PREP: begin
                corr_reg <= '0;
                if (job_reg.sxy[SXY_W-1] != job_reg.sy[SY_W-1]) begin
                    num_reg <= a_reg + b_reg;
                    neg_reg <= job_reg.sxy[SXY_W-1];
                end else if (a_reg >= b_reg) begin
                    num_reg <= a_reg - b_reg;
                    neg_reg <= job_reg.sxy[SXY_W-1];
                end else begin
                    num_reg <= b_reg - a_reg;
                    neg_reg <= !job_reg.sxy[SXY_W-1];
                end
            end
            B_DIVINIT: begin
                rem_reg  <= nsq_reg >> 3;
                rlow_reg <= {nsq_reg[2:0], {FRAC_SH{1'b0}}};
                q_reg    <= '0;
                u_reg    <= '0;
            end
            B_DIV: begin
                rem_reg  <= ge ? NSQ_W'(rem2 - {1'b0, den_reg}) : NSQ_W'(rem2);
                q_reg    <= {q_reg[Q_W-2:0], ge};
                rlow_reg <= rlow_reg << 1;
            end
            B_SQRT: begin
                if (trial_sq <= (2*U_W)'(q_reg)) begin
                    u_reg <= trial;
                end
            end
            B_FIN: begin
                if (neg_reg) begin
                    corr_reg <= CORR_W'(-m_val);
                end else begin
                    corr_reg <= (m_val > M_POS) ? CORR_W'(M_POS) : CORR_W'(m_val);
                end
            end
            default: begin
                t0_reg <= t0_reg;
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            step_reg    <= ST_NSYY;
            it_reg      <= '0;
            undef_reg   <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != B_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!q_stat.empty) begin
                        step_reg  <= ST_NSYY;
                        undef_reg <= 1'b0;
                        sat_reg   <= 1'b0;
                        state_reg <= B_MSTART;
                    end
                end
                B_MSTART: begin
                    state_reg <= B_MWAIT;
                end
                B_MWAIT: begin
                    if (mul_done) begin
                        if (step_reg == ST_SXSY) begin
                            state_reg <= B_PREP;
                        end else if (step_reg == ST_NSQ) begin
                            state_reg <= B_DIVINIT;
                        end else begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= B_MSTART;
                        end
                    end
                end
                B_PREP: begin
                    if (dx_reg == '0 || dy_reg == '0) begin
                        undef_reg <= 1'b1;
                        state_reg <= B_OUT;
                    end else begin
                        step_reg  <= ST_DEN;
                        state_reg <= B_MSTART;
                    end
                end
                B_DIVINIT: begin
                    it_reg <= '0;
                    if ((nsq_reg >> 3) >= den_reg) begin
                        sat_reg   <= 1'b1;
                        state_reg <= B_FIN;
                    end else begin
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_W'(Q_W - 1)) begin
                        it_reg    <= '0;
                        state_reg <= B_SQRT;
                    end
                end
                B_SQRT: begin
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IT_W'(U_W - 1)) begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN: begin
                    state_reg <= B_OUT;
                end
                B_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= job_reg.idx;
                        m_corr_reg  <= corr_reg;
                        m_undef_reg <= undef_reg;
                        m_last_reg  <= job_reg.last;
                        state_reg   <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== bench/pcc_checker.sv =====
// Checker for the Pearson correlation block: predicts coefficients and compares results.
module pcc_checker import pcc_pkg::*; #(
    parameter int FEATURES    = DEF_FEATURES,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [X_W-1:0]           s_feature_value,
    input  logic signed [Y_W-1:0]    s_target_value,
    input  logic                     s_end_of_sample,
    input  logic                     s_end_of_dataset,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [IDX_O_W-1:0]       m_feature_index,
    input  logic signed [CORR_W-1:0] m_correlation,
    input  logic                     m_undefined,
    input  logic                     m_last_result,
    output int                       errors,
    output int                       pending,
    output int                       results_seen
);

    typedef logic [255:0] big_t;

    typedef struct packed {
        logic [IDX_O_W-1:0]      idx;
        logic signed [CORR_W-1:0] corr;
        logic                    undef;
        logic                    last;
    } coeff_t;

    coeff_t coeff_q[$];

    logic [63:0]    sum_x  [FEATURES];
    logic [63:0]    sum_xx [FEATURES];
    longint         sum_xy [FEATURES];
    longint         sum_y;
    logic [63:0]    sum_yy;
    int unsigned    n_samples;
    int unsigned    position;

    assign pending = coeff_q.size();

    function automatic big_t floor_diff(big_t a, big_t b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    task automatic clear_sums();
        for (int k = 0; k < FEATURES; k++) begin
            sum_x[k] = 0;
            sum_xx[k] = 0;
            sum_xy[k] = 0;
        end
        sum_y = 0;
        sum_yy = 0;
        n_samples = 0;
        position = 0;
    endtask

    // Emit one coefficient per feature for the dataset just closed.
    task automatic predict_coefficients();
        big_t n, sy_mag, dy, sx, dx, a, b, num, rhs, den, t;
        logic sy_neg, a_neg, neg;
        int unsigned lo, hi, mid;
        coeff_t c;
        n = big_t'(n_samples);
        sy_neg = sum_y < 0;
        sy_mag = big_t'(magnitude(sum_y));
        dy = floor_diff(n * big_t'(sum_yy), sy_mag * sy_mag);
        for (int k = 0; k < FEATURES; k++) begin
            c.idx = IDX_O_W'(k);
            c.last = (k == FEATURES - 1);
            c.corr = '0;
            c.undef = 1'b0;
            sx = big_t'(sum_x[k]);
            dx = floor_diff(n * big_t'(sum_xx[k]), sx * sx);
            if (dx == 0 || dy == 0) begin
                c.undef = 1'b1;
            end else begin
                a_neg = sum_xy[k] < 0;
                a = n * big_t'(magnitude(sum_xy[k]));
                b = sx * sy_mag;
                if (a_neg != sy_neg) begin
                    num = a + b;
                    neg = a_neg;
                end else if (a >= b) begin
                    num = a - b;
                    neg = a_neg;
                end else begin
                    num = b - a;
                    neg = !a_neg;
                end
                rhs = (num * num) << 32;
                den = dx * dy;
                lo = 0;
                hi = 32768;
                while (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    t = big_t'(2 * mid - 1);
                    if (t * t * den <= rhs) lo = mid;
                    else hi = mid - 1;
                end
                if (neg) c.corr = CORR_W'(-lo);
                else c.corr = CORR_W'((lo > 32767) ? 32767 : lo);
            end
            coeff_q.insert(coeff_q.size(), c);
        end
        clear_sums();
    endtask

    task automatic accumulate(logic [X_W-1:0] xv, logic signed [Y_W-1:0] yv,
                              logic eos, logic eod);
        int unsigned p;
        logic live;
        longint x, y;
        p = (position >= FEATURES) ? FEATURES - 1 : position;
        live = n_samples < MAX_SAMPLES;
        x = longint'(xv);
        y = longint'(yv);
        if (live) begin
            sum_x[p] += 64'(x);
            sum_xx[p] += 64'(x * x);
            sum_xy[p] += x * y;
        end
        if (eos || eod || p == FEATURES - 1) begin
            if (live) begin
                sum_y += y;
                sum_yy += magnitude(y) * magnitude(y);
                n_samples++;
            end
            position = 0;
        end else begin
            position = p + 1;
        end
        if (eod) predict_coefficients();
    endtask

    initial begin
        errors = 0;
        results_seen = 0;
        clear_sums();
    end

    always @(posedge aclk) begin
        coeff_t want;
        if (!aresetn) begin
            clear_sums();
        end else begin
            if (s_valid && s_ready)
                accumulate(s_feature_value, s_target_value, s_end_of_sample,
                           s_end_of_dataset);
            if (m_valid && m_ready) begin
                results_seen++;
                if (coeff_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: idx=%0d corr=%0d undef=%0b last=%0b",
                                 m_feature_index, m_correlation, m_undefined,
                                 m_last_result);
                end else begin
                    want = coeff_q.pop_front();
                    if (m_feature_index !== want.idx || m_correlation !== want.corr ||
                        m_undefined !== want.undef || m_last_result !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp idx=%0d corr=%0d undef=%0b last=%0b / got idx=%0d corr=%0d undef=%0b last=%0b",
                                     want.idx, want.corr, want.undef, want.last,
                                     m_feature_index, m_correlation, m_undefined,
                                     m_last_result);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb_per_feature_pearson_correlation_top.sv =====
// Testbench top for the per-feature Pearson correlation block: stimulus and verdict.
module tb_per_feature_pearson_correlation_top;
    import pcc_pkg::*;

    localparam int FEATURES    = DEF_FEATURES;
    // Small sample limit so the overflow case fits in a short run.
    localparam int MAX_SAMPLES = 6;
    // Quiet cycles allowed: a full drain of all features with long output stalls.
    localparam int QUIET_LIMIT = 40000;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [X_W-1:0]           s_feature_value;
    logic signed [Y_W-1:0]    s_target_value;
    logic                     s_end_of_sample;
    logic                     s_end_of_dataset;
    logic                     m_valid;
    logic                     m_ready;
    logic [IDX_O_W-1:0]       m_feature_index;
    logic signed [CORR_W-1:0] m_correlation;
    logic                     m_undefined;
    logic                     m_last_result;

    int errors, pending, results_seen;
    int requests_sent, datasets_sent, quiet_cycles;
    bit no_gaps;   // when set, both sides run flat out

    per_feature_pearson_correlation_top #(
        .FEATURES(FEATURES), .MAX_SAMPLES(MAX_SAMPLES)
    ) dut (.*);

    pcc_checker #(.FEATURES(FEATURES), .MAX_SAMPLES(MAX_SAMPLES)) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one; none at all in flat-out stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_gaps || r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Stall the result channel at random; change m_ready only at the falling edge.
    initial begin
        int hold;
        m_ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (m_ready && pick_gap() > 0) begin
                m_ready <= 1'b0;
                hold = pick_gap();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Present one request after a random gap, hold it until accepted.
    // Entered and left at a falling edge, so valid gets one assignment per step.
    task automatic send(logic [X_W-1:0] x, logic signed [Y_W-1:0] y,
                        logic eos, logic eod);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_feature_value  <= x;
        s_target_value   <= y;
        s_end_of_sample  <= eos;
        s_end_of_dataset <= eod;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent++;
        if (eod) datasets_sent++;
    endtask

    // One sample of len elements; the last element of the last sample closes the dataset.
    task automatic send_sample(int len, logic signed [Y_W-1:0] y, bit mark_end,
                               bit close_set, bit wild);
        logic [X_W-1:0] x;
        for (int e = 0; e < len; e++) begin
            x = wild ? X_W'($urandom) : X_W'($urandom_range(0, 40));
            send(x, y, mark_end && e == len - 1, close_set && e == len - 1);
        end
    endtask

    // Random dataset: mostly well-formed samples, a few short or overlong ones.
    task automatic random_dataset();
        int samples, len, r;
        bit wild;
        logic signed [Y_W-1:0] y;
        samples = $urandom_range(2, 4);
        wild = $urandom_range(0, 2) == 0;
        for (int s = 0; s < samples; s++) begin
            r = $urandom_range(0, 9);
            len = (r < 7) ? FEATURES : (r < 9) ? $urandom_range(1, FEATURES - 1)
                                               : $urandom_range(FEATURES + 1, FEATURES + 5);
            y = wild ? Y_W'($urandom) : Y_W'($urandom_range(0, 200) - 100);
            send_sample(len, y, r != 9, s == samples - 1, wild);
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_feature_value = '0;
        s_target_value = '0;
        s_end_of_sample = 1'b0;
        s_end_of_dataset = 1'b0;
        requests_sent = 0;
        datasets_sent = 0;
        quiet_cycles = 0;
        no_gaps = 1'b0;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Single sample: fewer than two samples, all undefined.
        send(16'hFFFF, 16'sh7FFF, 1'b1, 1'b1);

        // Extremes: x swings between 0 and full scale against extreme targets.
        for (int s = 0; s < 4; s++)
            for (int e = 0; e < FEATURES; e++)
                send((s[0] ^ e[0]) ? 16'hFFFF : 16'h0000,
                     s[0] ? 16'sh8000 : 16'sh7FFF,
                     e == FEATURES - 1, s == 3 && e == FEATURES - 1);

        // Short samples, then an overlong one without end_of_sample.
        send(16'd5, 16'sd3, 1'b1, 1'b0);
        send(16'd9, -16'sd7, 1'b0, 1'b0);
        send(16'd1, -16'sd7, 1'b1, 1'b0);
        for (int e = 0; e < FEATURES + 3; e++)
            send(X_W'(e * 3), 16'sd100, 1'b0, e == FEATURES + 2);

        // Target varies inside a sample, which can push |r| past one.
        for (int s = 0; s < 2; s++)
            for (int e = 0; e < FEATURES; e++)
                send(X_W'(s * 7 + e), Y_W'((e % 2) ? 2000 : -2000 + s),
                     e == FEATURES - 1, s == 1 && e == FEATURES - 1);

        // Constant target: target variance zero everywhere.
        for (int s = 0; s < 2; s++)
            send_sample(FEATURES, 16'sd42, 1'b1, s == 1, 1'b0);

        // Overflow the sample counter with one-element samples; extras are dropped.
        no_gaps = 1'b1;
        for (int s = 0; s < MAX_SAMPLES + 6; s++)
            send(X_W'(s % 13), Y_W'(s % 17), 1'b1, s == MAX_SAMPLES + 5);
        no_gaps = 1'b0;

        // Random datasets, with idle-heavy and flat-out stretches in random order.
        for (int n = 0; requests_sent < 160 || n < 1; n++) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            random_dataset();
        end
        no_gaps = 1'b0;
        s_valid <= 1'b0;

        // Drain: wait for every predicted coefficient, then let the pipe settle.
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        $display("covered %0d requests in %0d datasets, %0d coefficients checked",
                 requests_sent, datasets_sent, results_seen);
        $display("included short, overlong and overfull datasets and extreme values");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
